/* rtl/channel_correlation_matrix_top_macros.svh */
// ----------------------------------------------------------------------------
// Channel correlation matrix assertion macros
// Concurrent assertion helpers for the correlation matrix block.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_CORRELATION_MATRIX_TOP_MACROS_SVH
`define CHANNEL_CORRELATION_MATRIX_TOP_MACROS_SVH

`ifndef SYNTH
`define CCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CCM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ccm_pkg.sv */
// ----------------------------------------------------------------------------
// Correlation matrix package
// Shared widths, register indexes and types.
// ----------------------------------------------------------------------------
`default_nettype none
package ccm_pkg;
    localparam int SAMPLE_W      = 16;
    localparam int STORE_DEPTH   = 256;
    localparam int ADDR_W        = 8;
    localparam int MAX_CHANNELS  = 8;
    localparam int MAX_SNAPSHOTS = 32;
    localparam int CH_W          = 3;
    localparam int CC_W          = 4;
    localparam int SC_W          = 6;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 6;
    localparam int VAR_W         = 42;
    localparam int MA_W          = 84;
    localparam int MB_W          = 42;
    localparam int MP_W          = MA_W + MB_W;

    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SNAPSHOT_COUNT = 2'd1;

    localparam logic [CC_W-1:0] CHANNEL_COUNT_RST  = 4'd6;
    localparam logic [SC_W-1:0] SNAPSHOT_COUNT_RST = 6'd5;

    typedef struct packed {
        logic            start;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic            done;
        logic [MP_W-1:0] p;
    } t_mul_rsp;
endpackage
`default_nettype wire

/* rtl/ccm_store.sv */
// ----------------------------------------------------------------------------
// Correlation matrix sample store
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none
module ccm_store (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [ccm_pkg::ADDR_W-1:0]    i_waddr,
    input  wire [ccm_pkg::SAMPLE_W-1:0]  i_wdata,
    input  wire [ccm_pkg::ADDR_W-1:0]    i_raddr_a,
    input  wire [ccm_pkg::ADDR_W-1:0]    i_raddr_b,
    output logic [ccm_pkg::SAMPLE_W-1:0] o_rdata_a,
    output logic [ccm_pkg::SAMPLE_W-1:0] o_rdata_b
);
    import ccm_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

/* rtl/ccm_mul.sv */
// ----------------------------------------------------------------------------
// Correlation matrix serial multiplier
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ccm_mul (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ccm_pkg::t_mul_req i_req,
    output ccm_pkg::t_mul_rsp o_rsp
);
    import ccm_pkg::*;

    logic            r_busy;
    logic            r_done;
    logic [MP_W-1:0] r_a;
    logic [MB_W-1:0] r_b;
    logic [MP_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_a    <= {{MB_W{1'b0}}, i_req.a};
                r_b    <= i_req.b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
                if ((r_b >> 1) == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;
endmodule
`default_nettype wire

/* rtl/channel_correlation_matrix_top.sv */
// ----------------------------------------------------------------------------
// Channel correlation matrix
// Pearson correlation of every ordered channel pair of a loaded sample block.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low, channel by channel. The
// last sample of a block raises busy; the block then emits C*C results, row by
// row, each on o_strobe for one cycle, and the receiver cannot stall them. Per
// pair it accumulates the sums through the two-port sample store and then
// forms the variances and the covariance; a pair with zero variance is
// emitted right after. Otherwise one shift-add multiplier computes vx*vy and
// cov^2 and up to sixteen search products, so the serial multiplier sets the
// pace of each pair.
`default_nettype none
module channel_correlation_matrix_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire signed [15:0]              i_sample,
    input  wire                            i_cfg_we,
    input  wire [ccm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire [ccm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                           o_strobe,
    output logic [2:0]                     o_row_channel,
    output logic [2:0]                     o_col_channel,
    output logic signed [15:0]             o_correlation,
    output logic                           o_undefined,
    output logic                           o_last_pair
);
    import ccm_pkg::*;

    `include "channel_correlation_matrix_top_macros.svh"

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_MU   = 5'd2;
    localparam logic [4:0] S_AD   = 5'd3;
    localparam logic [4:0] S_V1   = 5'd4;
    localparam logic [4:0] S_V2   = 5'd5;
    localparam logic [4:0] S_V3   = 5'd6;
    localparam logic [4:0] S_V4   = 5'd7;
    localparam logic [4:0] S_CHK  = 5'd8;
    localparam logic [4:0] S_PGO  = 5'd9;
    localparam logic [4:0] S_PWT  = 5'd10;
    localparam logic [4:0] S_QGO  = 5'd11;
    localparam logic [4:0] S_QWT  = 5'd12;
    localparam logic [4:0] S_SQ   = 5'd13;
    localparam logic [4:0] S_MGO  = 5'd14;
    localparam logic [4:0] S_MWT  = 5'd15;
    localparam logic [4:0] S_EMIT = 5'd16;

    logic [4:0]          r_state;
    logic [CC_W-1:0]     r_chan_cnt;
    logic [SC_W-1:0]     r_snap_cnt;
    logic [ADDR_W-1:0]   r_load;
    logic [CH_W-1:0]     r_i;
    logic [CH_W-1:0]     r_j;
    logic [ADDR_W-1:0]   r_ibase;
    logic [ADDR_W-1:0]   r_jbase;
    logic [SC_W-1:0]     r_k;
    logic signed [31:0]  r_pxx;
    logic signed [31:0]  r_pyy;
    logic signed [31:0]  r_pxy;
    logic signed [20:0]  r_sx;
    logic signed [20:0]  r_sy;
    logic signed [36:0]  r_sxx;
    logic signed [36:0]  r_syy;
    logic signed [36:0]  r_sxy;
    logic signed [43:0]  r_t1;
    logic signed [43:0]  r_t2;
    logic signed [43:0]  r_vx;
    logic signed [43:0]  r_vy;
    logic signed [43:0]  r_cov;
    logic [MA_W-1:0]     r_prod;
    logic [115:0]        r_rhs;
    logic [16:0]         r_lo;
    logic [16:0]         r_hi;
    logic [16:0]         r_mid;
    logic [31:0]         r_m;
    logic signed [15:0]  r_corr;
    logic                r_undef;

    logic [CC_W-1:0]     c_eff;
    logic [SC_W-1:0]     n_eff;
    logic [9:0]          total;
    logic                accept;
    logic                cfg_hit;
    logic                last_pair;
    logic [SAMPLE_W-1:0] rd_a;
    logic [SAMPLE_W-1:0] rd_b;
    logic signed [6:0]   ma1;
    logic signed [36:0]  mb1;
    logic signed [20:0]  ma2;
    logic signed [20:0]  mb2;
    logic signed [43:0]  m1;
    logic signed [41:0]  m2;
    logic signed [43:0]  cov_abs;
    logic [16:0]         mid_c;
    logic [15:0]         odd_c;
    logic [16:0]         lo_neg;
    t_mul_req            mreq;
    t_mul_rsp            mrsp;

    always_comb begin
        c_eff = r_chan_cnt;
        if (r_chan_cnt < CC_W'(2)) c_eff = CC_W'(2);
        if (r_chan_cnt > CC_W'(MAX_CHANNELS)) c_eff = CC_W'(MAX_CHANNELS);
        n_eff = r_snap_cnt;
        if (r_snap_cnt < SC_W'(2)) n_eff = SC_W'(2);
        if (r_snap_cnt > SC_W'(MAX_SNAPSHOTS)) n_eff = SC_W'(MAX_SNAPSHOTS);
    end

    assign total     = 10'(c_eff) * 10'(n_eff);
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_hit   = i_cfg_we && ((i_cfg_addr == REG_CHANNEL_COUNT)
                    || (i_cfg_addr == REG_SNAPSHOT_COUNT));
    assign last_pair = ({1'b0, r_i} == CC_W'(c_eff - 1'b1))
                    && ({1'b0, r_j} == CC_W'(c_eff - 1'b1));

    ccm_store u_store (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (r_load),
        .i_wdata   (i_sample),
        .i_raddr_a (r_ibase + ADDR_W'(r_k)),
        .i_raddr_b (r_jbase + ADDR_W'(r_k)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_comb begin
        ma1 = {1'b0, n_eff};
        case (r_state)
            S_V1: begin
                mb1 = r_sxx;
                ma2 = r_sx;
                mb2 = r_sx;
            end
            S_V2: begin
                mb1 = r_syy;
                ma2 = r_sy;
                mb2 = r_sy;
            end
            default: begin
                mb1 = r_sxy;
                ma2 = r_sx;
                mb2 = r_sy;
            end
        endcase
    end

    assign m1      = 44'(ma1 * mb1);
    assign m2      = ma2 * mb2;
    assign cov_abs = r_cov[43] ? -r_cov : r_cov;
    assign mid_c   = 17'((18'(r_lo) + 18'(r_hi) + 18'd1) >> 1);
    assign odd_c   = 16'((mid_c << 1) - 17'd1);
    assign lo_neg  = -r_lo;

    always_comb begin
        mreq.start = 1'b0;
        mreq.a     = r_prod;
        mreq.b     = MB_W'(r_m);
        case (r_state)
            S_PGO: begin
                mreq.start = 1'b1;
                mreq.a     = MA_W'(r_vx[VAR_W-1:0]);
                mreq.b     = r_vy[VAR_W-1:0];
            end
            S_QGO: begin
                mreq.start = 1'b1;
                mreq.a     = MA_W'(cov_abs[VAR_W-1:0]);
                mreq.b     = cov_abs[VAR_W-1:0];
            end
            S_MGO: begin
                mreq.start = 1'b1;
            end
            default: begin
                mreq.start = 1'b0;
            end
        endcase
    end

    ccm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rsp   (mrsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_chan_cnt <= CHANNEL_COUNT_RST;
            r_snap_cnt <= SNAPSHOT_COUNT_RST;
            r_load     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_CHANNEL_COUNT) begin
                    r_chan_cnt <= i_cfg_data[CC_W-1:0];
                end else if (i_cfg_addr == REG_SNAPSHOT_COUNT) begin
                    r_snap_cnt <= i_cfg_data[SC_W-1:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (10'(r_load) + 10'd1 >= total) begin
                            r_load  <= '0;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_ibase <= '0;
                            r_jbase <= '0;
                            r_k     <= '0;
                            r_sx    <= '0;
                            r_sy    <= '0;
                            r_sxx   <= '0;
                            r_syy   <= '0;
                            r_sxy   <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_load <= cfg_hit ? '0 : r_load + 1'b1;
                        end
                    end else if (cfg_hit) begin
                        r_load <= '0;
                    end
                end
                S_RD: begin
                    r_state <= S_MU;
                end
                S_MU: begin
                    r_pxx   <= $signed(rd_a) * $signed(rd_a);
                    r_pyy   <= $signed(rd_b) * $signed(rd_b);
                    r_pxy   <= $signed(rd_a) * $signed(rd_b);
                    r_state <= S_AD;
                end
                S_AD: begin
                    r_sx  <= r_sx + 21'($signed(rd_a));
                    r_sy  <= r_sy + 21'($signed(rd_b));
                    r_sxx <= r_sxx + 37'(r_pxx);
                    r_syy <= r_syy + 37'(r_pyy);
                    r_sxy <= r_sxy + 37'(r_pxy);
                    if (r_k + 1'b1 == n_eff) begin
                        r_state <= S_V1;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_V1: begin
                    r_t1    <= m1;
                    r_t2    <= 44'(m2);
                    r_state <= S_V2;
                end
                S_V2: begin
                    r_vx    <= r_t1 - r_t2;
                    r_t1    <= m1;
                    r_t2    <= 44'(m2);
                    r_state <= S_V3;
                end
                S_V3: begin
                    r_vy    <= r_t1 - r_t2;
                    r_t1    <= m1;
                    r_t2    <= 44'(m2);
                    r_state <= S_V4;
                end
                S_V4: begin
                    r_cov   <= r_t1 - r_t2;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_vx <= 44'sd0 || r_vy <= 44'sd0) begin
                        r_undef <= 1'b1;
                        r_corr  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_undef <= 1'b0;
                        r_state <= S_PGO;
                    end
                end
                S_PGO: begin
                    r_state <= S_PWT;
                end
                S_PWT: begin
                    if (mrsp.done) begin
                        r_prod  <= mrsp.p[MA_W-1:0];
                        r_state <= S_QGO;
                    end
                end
                S_QGO: begin
                    r_state <= S_QWT;
                end
                S_QWT: begin
                    if (mrsp.done) begin
                        r_rhs   <= {mrsp.p[MA_W-1:0], 32'd0};
                        r_lo    <= '0;
                        r_hi    <= 17'd32768;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= mid_c;
                        r_m     <= odd_c * odd_c;
                        r_state <= S_MGO;
                    end else begin
                        if (r_cov[43]) begin
                            r_corr <= lo_neg[15:0];
                        end else if (r_lo > 17'd32767) begin
                            r_corr <= 16'sd32767;
                        end else begin
                            r_corr <= r_lo[15:0];
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_MGO: begin
                    r_state <= S_MWT;
                end
                S_MWT: begin
                    if (mrsp.done) begin
                        if (mrsp.p <= MP_W'(r_rhs)) begin
                            r_lo <= r_mid;
                        end else begin
                            r_hi <= r_mid - 1'b1;
                        end
                        r_state <= S_SQ;
                    end
                end
                S_EMIT: begin
                    r_k   <= '0;
                    r_sx  <= '0;
                    r_sy  <= '0;
                    r_sxx <= '0;
                    r_syy <= '0;
                    r_sxy <= '0;
                    if (last_pair) begin
                        r_state <= S_IDLE;
                    end else begin
                        if ({1'b0, r_j} == CC_W'(c_eff - 1'b1)) begin
                            r_j     <= '0;
                            r_jbase <= '0;
                            r_i     <= r_i + 1'b1;
                            r_ibase <= r_ibase + ADDR_W'(n_eff);
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_jbase <= r_jbase + ADDR_W'(n_eff);
                        end
                        r_state <= S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe      = (r_state == S_EMIT);
    assign o_row_channel = r_i;
    assign o_col_channel = r_j;
    assign o_correlation = r_corr;
    assign o_undefined   = r_undef;
    assign o_last_pair   = o_strobe && last_pair;

    `CCM_ASSERT_SAME(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)
    `CCM_ASSERT_SAME(a_undef_zero, i_clk, i_rst_n, o_strobe && o_undefined, o_correlation == 16'sd0)
    `CCM_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_strobe && o_last_pair, !o_strobe && !busy)
    `CCM_ASSERT_NEXT(a_accept_quiet, i_clk, i_rst_n, start && !busy, !o_strobe)
endmodule
`default_nettype wire

/* tb/channel_correlation_matrix_top_test.sv */
// ----------------------------------------------------------------------------
// Channel correlation matrix testbench
// Loads sample blocks under many channel and snapshot settings and checks
// every correlation result against an exact integer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module channel_correlation_matrix_top_test;
    import ccm_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] corr;
        logic               undef;
        logic               last;
    } t_pair;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic signed [15:0]    i_sample;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_strobe;
    logic [2:0]            o_row_channel;
    logic [2:0]            o_col_channel;
    logic signed [15:0]    o_correlation;
    logic                  o_undefined;
    logic                  o_last_pair;

    channel_correlation_matrix_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_sample      (i_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_row_channel (o_row_channel),
        .o_col_channel (o_col_channel),
        .o_correlation (o_correlation),
        .o_undefined   (o_undefined),
        .o_last_pair   (o_last_pair)
    );

    logic [3:0]         chan_reg;
    logic [5:0]         snap_reg;
    logic signed [15:0] block_mem [256];
    int                 fill_count;
    t_pair              pending_pairs [$];
    int                 error_count;
    int                 idle_cycles;
    int                 items_sent;
    logic signed [15:0] chan_buf [8][32];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int eff_chans();
        return (chan_reg < 2) ? 2 : (chan_reg > 8) ? 8 : int'(chan_reg);
    endfunction

    function automatic int eff_snaps();
        int n;
        n = (snap_reg < 2) ? 2 : (snap_reg > 32) ? 32 : int'(snap_reg);
        if (n > 256 / eff_chans()) n = 256 / eff_chans();
        return n;
    endfunction

    // Q1.15 of cov / sqrt(vx*vy) by search on squared odd multiples
    function automatic logic signed [15:0] pearson_q15(longint cov, longint vx, longint vy);
        logic [159:0] prod;
        logic [159:0] rhs;
        logic [159:0] lhs;
        logic [63:0]  mag;
        longint unsigned odd;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        mag = (cov < 0) ? 64'(-cov) : 64'(cov);
        prod = 160'(vx) * 160'(vy);
        rhs = (160'(mag) * 160'(mag)) << 32;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 2 * mid - 1;
            lhs = prod * 160'(odd * odd);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        if (cov < 0) return -16'(lo);
        return (lo > 32767) ? 16'sd32767 : 16'(lo);
    endfunction

    task automatic predict_sample(input logic signed [15:0] s);
        int c;
        int n;
        longint sx, sy, sxx, syy, sxy, x, y, vx, vy, cov;
        t_pair p;
        c = eff_chans();
        n = eff_snaps();
        block_mem[fill_count] = s;
        if (fill_count + 1 < c * n) begin
            fill_count++;
            return;
        end
        fill_count = 0;
        for (int i = 0; i < c; i++) begin
            for (int j = 0; j < c; j++) begin
                sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
                for (int k = 0; k < n; k++) begin
                    x = block_mem[i * n + k];
                    y = block_mem[j * n + k];
                    sx += x; sy += y; sxx += x * x; syy += y * y; sxy += x * y;
                end
                vx = n * sxx - sx * sx;
                vy = n * syy - sy * sy;
                cov = n * sxy - sx * sy;
                p.row = 3'(i);
                p.col = 3'(j);
                p.undef = (vx <= 0 || vy <= 0);
                p.corr = p.undef ? 16'sd0 : pearson_q15(cov, vx, vy);
                p.last = (i == c - 1 && j == c - 1);
                pending_pairs.push_back(p);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_pair p;
        if (i_rst_n && o_strobe) begin
            if (pending_pairs.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                p = pending_pairs.pop_front();
                if (o_row_channel !== p.row)
                    report_mismatch("row_channel", int'(o_row_channel), int'(p.row));
                if (o_col_channel !== p.col)
                    report_mismatch("col_channel", int'(o_col_channel), int'(p.col));
                if (o_correlation !== p.corr)
                    report_mismatch("correlation", int'(o_correlation), int'(p.corr));
                if (o_undefined !== p.undef)
                    report_mismatch("undefined", int'(o_undefined), int'(p.undef));
                if (o_last_pair !== p.last)
                    report_mismatch("last_pair", int'(o_last_pair), int'(p.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("channel_correlation_matrix_top_test: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(input logic signed [15:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_sample <= s;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_sample(s);
        items_sent++;
    endtask

    // hold off until every pending result has come out
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CHANNEL_COUNT) begin
            chan_reg = d[3:0];
            fill_count = 0;
        end else if (idx == REG_SNAPSHOT_COUNT) begin
            snap_reg = d;
            fill_count = 0;
        end
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
            default: return 16'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // fill one block; each channel is fresh, constant, a copy or a negated copy
    task automatic send_block(input bit shaped);
        int c;
        int n;
        int src;
        int kind;
        logic signed [15:0] v;
        c = eff_chans();
        n = eff_snaps();
        for (int i = 0; i < c; i++) begin
            kind = shaped ? $urandom_range(0, 5) : 0;
            src = (i == 0) ? 0 : $urandom_range(0, i - 1);
            v = rand_sample();
            for (int k = 0; k < n; k++) begin
                case (kind)
                    1: chan_buf[i][k] = v;
                    2: chan_buf[i][k] = (i == 0) ? rand_sample() : chan_buf[src][k];
                    3: chan_buf[i][k] = (i == 0 || chan_buf[src][k] == -16'sh8000)
                                        ? rand_sample() : -chan_buf[src][k];
                    default: chan_buf[i][k] = rand_sample();
                endcase
                send_sample(chan_buf[i][k]);
            end
        end
    endtask

    task automatic test_reset_settings();
        send_block(1'b1);
    endtask

    task automatic test_extremes();
        write_reg(REG_CHANNEL_COUNT, 6'd2);
        write_reg(REG_SNAPSHOT_COUNT, 6'd2);
        send_sample(16'sh7fff); send_sample(-16'sh8000);
        send_sample(-16'sh8000); send_sample(16'sh7fff);
        send_sample(16'sh7fff); send_sample(16'sh7fff);
        send_sample(16'sh0001); send_sample(-16'sh0001);
        send_sample(16'sh0000); send_sample(16'sh0003);
        send_sample(-16'sh8000); send_sample(16'sh7fff);
        send_sample(16'sh5555); send_sample(-16'sh5556);
        send_sample(16'sh1234); send_sample(16'sh1234);
    endtask

    task automatic test_special_pairs();
        write_reg(REG_CHANNEL_COUNT, 6'd3);
        write_reg(REG_SNAPSHOT_COUNT, 6'd3);
        // rising sequence, its negation, constant
        send_sample(16'sd1); send_sample(16'sd2); send_sample(16'sd4);
        send_sample(-16'sd1); send_sample(-16'sd2); send_sample(-16'sd4);
        send_sample(16'sd9); send_sample(16'sd9); send_sample(16'sd9);
    endtask

    task automatic test_register_bounds();
        write_reg(REG_SPARE_A, 6'd7);
        write_reg(REG_SPARE_B, 6'd63);
        write_reg(REG_CHANNEL_COUNT, 6'd0);
        write_reg(REG_SNAPSHOT_COUNT, 6'd0);
        send_block(1'b1);
        write_reg(REG_CHANNEL_COUNT, 6'd1);
        write_reg(REG_SNAPSHOT_COUNT, 6'd1);
        send_block(1'b1);
        write_reg(REG_CHANNEL_COUNT, 6'd15);
        write_reg(REG_SNAPSHOT_COUNT, 6'd4);
        send_block(1'b1);
        write_reg(REG_CHANNEL_COUNT, 6'd4);
        write_reg(REG_SNAPSHOT_COUNT, 6'd63);
        send_block(1'b0);
    endtask

    task automatic test_restart_on_write();
        write_reg(REG_CHANNEL_COUNT, 6'd2);
        write_reg(REG_SNAPSHOT_COUNT, 6'd4);
        repeat (5) send_sample(rand_sample());
        write_reg(REG_SPARE_A, 6'd0);
        repeat (2) send_sample(rand_sample());
        write_reg(REG_SNAPSHOT_COUNT, 6'd3);
        send_block(1'b1);
    endtask

    task automatic test_random_blocks();
        while (items_sent < 320) begin
            if ($urandom_range(0, 9) < 8) begin
                write_reg(REG_CHANNEL_COUNT, 6'($urandom_range(2, 4)));
                write_reg(REG_SNAPSHOT_COUNT, 6'($urandom_range(2, 7)));
            end else begin
                write_reg(REG_CHANNEL_COUNT, 6'($urandom_range(0, 63) & 6'h37));
                write_reg(REG_SNAPSHOT_COUNT, 6'($urandom_range(0, 63) & 6'h27));
            end
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 5)) send_sample(rand_sample());
            else
                send_block($urandom_range(0, 4) != 0);
        end
    endtask

    initial begin
        start = 1'b0;
        i_sample = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_CHANNEL_COUNT;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        items_sent = 0;
        fill_count = 0;
        chan_reg = CHANNEL_COUNT_RST;
        snap_reg = SNAPSHOT_COUNT_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_extremes();
        test_special_pairs();
        test_restart_on_write();
        test_register_bounds();
        test_random_blocks();
        settle();

        if (error_count == 0) begin
            $display("channel_correlation_matrix_top_test: done, clean");
        end else begin
            $display("channel_correlation_matrix_top_test: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
